// File: sv/task_scheduler_semaphore_engine_top_assert.svh
// Assertion macros for the task scheduler and semaphore engine.
// Used by the top level; depends on nothing else.
`ifndef TASK_SCHEDULER_SEMAPHORE_ENGINE_TOP_ASSERT_SVH
`define TASK_SCHEDULER_SEMAPHORE_ENGINE_TOP_ASSERT_SVH
// Implication checked on every rising clock edge outside reset.
`define TSE_ASSERT_IMP(label, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define TSE_ASSERT_NEXT(label, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
    else $error("assertion failed");
`endif

// File: sv/tse_pkg.sv
// Shared types and constants of the task scheduler and semaphore engine.
// No dependencies.
`timescale 1ns / 1ps
package tse_pkg;
  localparam int TasksDef = 12;
  localparam int SemaphoresDef = 5;
  localparam int QueueDepthDef = 5;
  localparam logic [15:0] COUNT_MAX = 16'hFFFF;

  typedef enum logic [3:0] {
    M_TICK = 4'd0, M_SCHED = 4'd1, M_SLEEP = 4'd2, M_WAIT = 4'd3, M_POST = 4'd4,
    M_RESTART = 4'd5, M_STOP = 4'd6, M_SETPRI = 4'd7, M_INITSEM = 4'd8
  } mode_t;

  typedef enum logic [2:0] {
    ST_INVALID = 3'd0, ST_UNRUN = 3'd1, ST_READY = 3'd2, ST_DELAYED = 3'd3,
    ST_BLOCKED = 3'd4, ST_KILLED = 3'd5
  } tstate_t;

  typedef enum logic [1:0] {
    E_OK = 2'd0, E_QFULL = 2'd1, E_NORUN = 2'd2, E_RANGE = 2'd3
  } err_t;

  localparam logic CFG_PREEMPT = 1'b0;
  localparam logic CFG_PRIO = 1'b1;

  typedef struct packed {
    logic [3:0] task_out;
    logic       task_valid;
    logic       fresh_start;
    logic       switch_request;
    logic [1:0] error;
  } result_t;
endpackage

// File: sv/task_scheduler_semaphore_engine_top.sv
// Top level of the task scheduler and semaphore engine.
// Depends on tse_pkg and task_scheduler_semaphore_engine_top_assert.svh.
`timescale 1ns / 1ps
// One item at a time; s_tready is low while an item is at work. The mode of an item
// travels on s_tuser, and the task_valid flag of a result on m_tuser. Tick, schedule
// and stop/restart/post (queue removal) walk the task table or a wait queue through
// one shared sequencer step per cycle. Tick walks the table once; schedule in priority
// mode walks it once for the best priority and then scans for a task that has it, round
// robin scans at most once; queue removal walks the wait queue; other modes take one step.
// A finished result sits in an output register; s_tready rises the cycle after the
// result is registered, once that register is free or being read.
module task_scheduler_semaphore_engine_top #(
  parameter int TASKS = tse_pkg::TasksDef,
  parameter int SEMAPHORES = tse_pkg::SemaphoresDef,
  parameter int QUEUE_DEPTH = tse_pkg::QueueDepthDef
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // task_index[3:0], sem_index[6:4], value[38:7], new_priority[41:39]
  input  logic [47:0] s_tdata,
  // mode[3:0]
  input  logic [3:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // task_out[3:0], fresh_start[4], switch_request[5], error[7:6]
  output logic [7:0]  m_tdata,
  // task_valid[0]
  output logic        m_tuser,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic        cfg_data
);
  import tse_pkg::*;
  localparam int TW = 4;
  localparam int SW = 3;
  localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int LW = $clog2(QUEUE_DEPTH + 1);
  localparam int CW = $clog2(2 * TASKS + 2);

  typedef enum logic [2:0] {S_IDLE, S_TICK, S_BEST, S_SCAN, S_SIMPLE, S_DEQ, S_DONE}
    fsm_t;

  fsm_t state;
  logic preempt_enable, priority_mode;
  tstate_t task_state [TASKS];
  logic [2:0] task_priority [TASKS];
  logic [31:0] task_ticks [TASKS];
  logic [SW-1:0] task_wait_sem [TASKS];
  logic task_waiting [TASKS];
  logic [15:0] sem_count [SEMAPHORES];
  logic [LW-1:0] sem_queue_len [SEMAPHORES];
  logic [TW-1:0] sem_queue [SEMAPHORES][QUEUE_DEPTH];
  logic [TW-1:0] current_task, last_pick;

  logic [3:0] mode;
  logic [TW-1:0] ti, scan_t, deq_t, pick;
  logic [SW-1:0] si, deq_s;
  logic [31:0] val;
  logic [2:0] np;
  logic [3:0] best;
  logic [CW-1:0] cnt;
  logic [QW-1:0] qpos;
  logic deq_hit, deq_post;
  result_t res;
  logic out_full;
  logic [TW-1:0] cur;
  logic [TW-1:0] first_t;
  logic [TW-1:0] head_t;
  logic runnable_s;
  logic simple_deq;

  assign s_tready = (state == S_IDLE) && (!out_full || m_tready);
  assign m_tvalid = out_full;
  assign m_tdata = {res.error, res.switch_request, res.fresh_start, res.task_out};
  assign m_tuser = res.task_valid;

  assign cur = (int'(current_task) >= TASKS) ? current_task - TW'(TASKS) : current_task;
  assign first_t = (int'(last_pick) == TASKS - 1) ? '0 : last_pick + 1'b1;
  assign head_t = (int'(sem_queue[si][0]) >= TASKS) ? sem_queue[si][0] - TW'(TASKS)
                                                    : sem_queue[si][0];
  assign runnable_s = task_state[scan_t] == ST_UNRUN || task_state[scan_t] == ST_READY;
  assign deq_s = task_wait_sem[deq_t];

  always_comb begin
    case (mode)
      M_POST: simple_deq = int'(si) < SEMAPHORES && sem_queue_len[si] != '0;
      M_RESTART: simple_deq = int'(ti) < TASKS;
      M_STOP: simple_deq = int'(ti) < TASKS && task_state[ti] != ST_INVALID;
      default: simple_deq = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_full <= 1'b0;
      preempt_enable <= 1'b0;
      priority_mode <= 1'b0;
      for (int t = 0; t < TASKS; t++) begin
        task_state[t] <= ST_INVALID;
        task_priority[t] <= 3'd7;
        task_ticks[t] <= 32'd0;
        task_wait_sem[t] <= '0;
        task_waiting[t] <= 1'b0;
      end
      for (int s = 0; s < SEMAPHORES; s++) begin
        sem_count[s] <= '0;
        sem_queue_len[s] <= '0;
      end
      current_task <= '0;
      last_pick <= TW'(TASKS - 1);
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_PREEMPT) preempt_enable <= cfg_data;
        else priority_mode <= cfg_data;
      end
      if (m_tvalid && m_tready) out_full <= 1'b0;
      case (state)
        S_IDLE: begin
          if (s_tvalid && s_tready) begin
            mode <= s_tuser;
            ti <= s_tdata[3:0];
            si <= s_tdata[6:4];
            val <= s_tdata[38:7];
            np <= s_tdata[41:39];
            res <= '0;
            cnt <= '0;
            best <= 4'd8;
            scan_t <= (s_tuser == M_SCHED && !priority_mode) ? first_t : '0;
            case (s_tuser)
              M_TICK: state <= S_TICK;
              M_SCHED: state <= priority_mode ? S_BEST : S_SCAN;
              default: state <= S_SIMPLE;
            endcase
          end
        end
        S_TICK: begin
          if (task_state[scan_t] == ST_DELAYED) begin
            if (task_ticks[scan_t] == 32'd0) task_state[scan_t] <= ST_READY;
            else task_ticks[scan_t] <= task_ticks[scan_t] - 32'd1;
          end
          scan_t <= scan_t + 1'b1;
          if (int'(scan_t) == TASKS - 1) begin
            res.switch_request <= preempt_enable;
            state <= S_DONE;
          end
        end
        S_BEST: begin
          if (runnable_s && {1'b0, task_priority[scan_t]} < best)
            best <= {1'b0, task_priority[scan_t]};
          if (int'(scan_t) == TASKS - 1) begin
            state <= S_SCAN;
            scan_t <= first_t;
          end else scan_t <= scan_t + 1'b1;
        end
        S_SCAN: begin
          if (runnable_s && (!priority_mode || {1'b0, task_priority[scan_t]} == best)) begin
            res.fresh_start <= task_state[scan_t] == ST_UNRUN;
            task_state[scan_t] <= ST_READY;
            last_pick <= scan_t;
            current_task <= scan_t;
            res.task_out <= scan_t;
            res.task_valid <= 1'b1;
            state <= S_DONE;
          end else if (cnt == CW'(TASKS - 1)) begin
            res.error <= E_NORUN;
            state <= S_DONE;
          end else begin
            cnt <= cnt + 1'b1;
            scan_t <= (int'(scan_t) == TASKS - 1) ? '0 : scan_t + 1'b1;
          end
        end
        S_SIMPLE: begin
          state <= simple_deq ? S_DEQ : S_DONE;
          deq_post <= (mode == M_POST);
          qpos <= '0;
          deq_hit <= 1'b0;
          case (mode)
            M_SLEEP: if (task_state[cur] == ST_READY) begin
              task_ticks[cur] <= val;
              task_state[cur] <= ST_DELAYED;
              res.switch_request <= 1'b1;
            end
            M_WAIT: begin
              if (int'(si) >= SEMAPHORES) res.error <= E_RANGE;
              else if (task_state[cur] == ST_READY) begin
                if (sem_count[si] != 16'd0) sem_count[si] <= sem_count[si] - 16'd1;
                else if (sem_queue_len[si] >= LW'(QUEUE_DEPTH)) res.error <= E_QFULL;
                else begin
                  sem_queue[si][QW'(sem_queue_len[si])] <= cur;
                  sem_queue_len[si] <= sem_queue_len[si] + 1'b1;
                  task_wait_sem[cur] <= si;
                  task_waiting[cur] <= 1'b1;
                  task_state[cur] <= ST_BLOCKED;
                  res.switch_request <= 1'b1;
                end
              end
            end
            M_POST: begin
              if (int'(si) >= SEMAPHORES) res.error <= E_RANGE;
              else if (sem_queue_len[si] != '0) deq_t <= head_t;
              else if (sem_count[si] < COUNT_MAX) sem_count[si] <= sem_count[si] + 16'd1;
            end
            M_RESTART, M_STOP: begin
              if (int'(ti) >= TASKS) res.error <= E_RANGE;
              else deq_t <= ti;
            end
            M_SETPRI: if (int'(ti) >= TASKS) res.error <= E_RANGE;
              else task_priority[ti] <= np;
            M_INITSEM: if (int'(si) >= SEMAPHORES) res.error <= E_RANGE;
              else sem_count[si] <= val[15:0];
            default: ;
          endcase
        end
        S_DEQ: begin
          if (!task_waiting[deq_t] || int'(deq_s) >= SEMAPHORES ||
              LW'(qpos) >= sem_queue_len[deq_s] || int'(qpos) == QUEUE_DEPTH - 1
              && !deq_hit && sem_queue[deq_s][qpos] != deq_t) begin
            if (task_waiting[deq_t] && int'(deq_s) < SEMAPHORES && deq_hit)
              sem_queue_len[deq_s] <= sem_queue_len[deq_s] - 1'b1;
            task_waiting[deq_t] <= 1'b0;
            task_wait_sem[deq_t] <= '0;
            if (deq_post) begin
              task_state[deq_t] <= ST_READY;
              res.task_out <= deq_t;
              res.task_valid <= 1'b1;
            end else if (mode == M_RESTART) task_state[deq_t] <= ST_UNRUN;
            else task_state[deq_t] <= ST_KILLED;
            state <= S_DONE;
          end else begin
            if (deq_hit || sem_queue[deq_s][qpos] == deq_t) begin
              deq_hit <= 1'b1;
              if (int'(qpos) + 1 < QUEUE_DEPTH)
                sem_queue[deq_s][qpos] <= sem_queue[deq_s][QW'(int'(qpos) + 1)];
            end
            if (int'(qpos) + 1 < QUEUE_DEPTH) qpos <= qpos + 1'b1;
            else begin
              if (deq_hit || sem_queue[deq_s][qpos] == deq_t)
                sem_queue_len[deq_s] <= sem_queue_len[deq_s] - 1'b1;
              task_waiting[deq_t] <= 1'b0;
              task_wait_sem[deq_t] <= '0;
              if (deq_post) begin
                task_state[deq_t] <= ST_READY;
                res.task_out <= deq_t;
                res.task_valid <= 1'b1;
              end else if (mode == M_RESTART) task_state[deq_t] <= ST_UNRUN;
              else task_state[deq_t] <= ST_KILLED;
              state <= S_DONE;
            end
          end
        end
        S_DONE: begin
          if (!out_full || m_tready) begin
            out_full <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign pick = scan_t;

`include "task_scheduler_semaphore_engine_top_assert.svh"
  `TSE_ASSERT_IMP(a_busy_not_ready, state != S_IDLE, !s_tready)
  `TSE_ASSERT_NEXT(a_accept_busy, s_tvalid && s_tready, state != S_IDLE)
  `TSE_ASSERT_IMP(a_fresh_valid, m_tvalid && res.fresh_start, res.task_valid)
  `TSE_ASSERT_IMP(a_pick_range, state == S_SCAN, int'(pick) < TASKS)
endmodule

// File: sim/tb_task_scheduler_semaphore_engine_top.sv
// Self-checking bench for the task scheduler and semaphore engine top level.
// Predicts each result from a local copy of the task and semaphore tables.
// Depends on tse_pkg and task_scheduler_semaphore_engine_top.
`timescale 1ns / 1ps
module tb_task_scheduler_semaphore_engine_top;
  import tse_pkg::*;

  localparam int NT = 12;
  localparam int NS = 5;
  localparam int QD = 5;
  localparam int LIMIT = 2000000;

  typedef struct packed {
    logic [2:0]  new_priority;
    logic [31:0] value;
    logic [2:0]  sem_index;
    logic [3:0]  task_index;
    logic [3:0]  mode;
  } op_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [47:0] s_tdata = '0;
  logic [3:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [7:0] m_tdata;
  logic m_tuser;
  logic cfg_we = 1'b0;
  logic cfg_index = 1'b0;
  logic cfg_data = 1'b0;

  task_scheduler_semaphore_engine_top dut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // scheduler model state
  tstate_t     k_state [NT];
  logic [2:0]  k_prio [NT];
  logic [31:0] k_ticks [NT];
  logic [2:0]  k_wsem [NT];
  logic        k_waiting [NT];
  logic [15:0] k_count [NS];
  int          k_qlen [NS];
  logic [3:0]  k_queue [NS][QD];
  int          k_cur;
  int          k_last;
  logic        k_preempt;
  logic        k_prio_mode;

  op_t     pending_ops[$];
  result_t expected_results[$];
  int errors = 0;
  int cycles = 0;
  logic calm = 1'b0;
  int hold_cycles = 0;
  int tx_gap = 0;
  int rx_gap = 0;

  function automatic bit is_runnable(int t);
    return k_state[t] == ST_UNRUN || k_state[t] == ST_READY;
  endfunction

  function automatic void unqueue(int t);
    int s;
    int len;
    if (!k_waiting[t]) return;
    s = k_wsem[t];
    k_waiting[t] = 1'b0;
    k_wsem[t] = '0;
    len = k_qlen[s];
    for (int j = 0; j < len; j++) begin
      if (k_queue[s][j] == t) begin
        for (int k = j; k + 1 < len; k++) k_queue[s][k] = k_queue[s][k + 1];
        k_qlen[s] = len - 1;
        return;
      end
    end
  endfunction

  function automatic result_t kernel_step(op_t op);
    result_t r;
    int best;
    int pick;
    int t;
    int cur;
    int si;
    int ti;
    r = '0;
    cur = k_cur % NT;
    si = op.sem_index;
    ti = op.task_index;
    case (op.mode)
      M_TICK: begin
        for (int i = 0; i < NT; i++)
          if (k_state[i] == ST_DELAYED) begin
            if (k_ticks[i] == 0) k_state[i] = ST_READY;
            else k_ticks[i]--;
          end
        r.switch_request = k_preempt;
      end
      M_SCHED: begin
        best = 8;
        pick = NT;
        if (k_prio_mode)
          for (int i = 0; i < NT; i++)
            if (is_runnable(i) && k_prio[i] < best) best = int'(k_prio[i]);
        for (int k = 1; k <= NT; k++) begin
          t = (k_last + k) % NT;
          if (pick == NT && is_runnable(t) && (!k_prio_mode || k_prio[t] == best))
            pick = t;
        end
        if (pick == NT) r.error = E_NORUN;
        else begin
          r.fresh_start = k_state[pick] == ST_UNRUN;
          k_state[pick] = ST_READY;
          k_last = pick;
          k_cur = pick;
          r.task_out = 4'(pick);
          r.task_valid = 1'b1;
        end
      end
      M_SLEEP: begin
        if (k_state[cur] == ST_READY) begin
          k_ticks[cur] = op.value;
          k_state[cur] = ST_DELAYED;
          r.switch_request = 1'b1;
        end
      end
      M_WAIT: begin
        if (si >= NS) r.error = E_RANGE;
        else if (k_state[cur] == ST_READY) begin
          if (k_count[si] != 0) k_count[si]--;
          else if (k_qlen[si] >= QD) r.error = E_QFULL;
          else begin
            k_queue[si][k_qlen[si]] = 4'(cur);
            k_qlen[si]++;
            k_wsem[cur] = 3'(si);
            k_waiting[cur] = 1'b1;
            k_state[cur] = ST_BLOCKED;
            r.switch_request = 1'b1;
          end
        end
      end
      M_POST: begin
        if (si >= NS) r.error = E_RANGE;
        else if (k_qlen[si] > 0) begin
          t = int'(k_queue[si][0]) % NT;
          unqueue(t);
          k_state[t] = ST_READY;
          r.task_out = 4'(t);
          r.task_valid = 1'b1;
        end else if (k_count[si] != COUNT_MAX) k_count[si]++;
      end
      M_RESTART: begin
        if (ti >= NT) r.error = E_RANGE;
        else begin
          unqueue(ti);
          k_state[ti] = ST_UNRUN;
        end
      end
      M_STOP: begin
        if (ti >= NT) r.error = E_RANGE;
        else if (k_state[ti] != ST_INVALID) begin
          unqueue(ti);
          k_state[ti] = ST_KILLED;
        end
      end
      M_SETPRI: begin
        if (ti >= NT) r.error = E_RANGE;
        else k_prio[ti] = op.new_priority;
      end
      M_INITSEM: begin
        if (si >= NS) r.error = E_RANGE;
        else k_count[si] = op.value[15:0];
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic report(string what, logic [15:0] got, logic [15:0] want);
    errors++;
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
  endtask

  // driver
  always @(posedge clk) begin
    op_t op;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        expected_results.push_back(kernel_step(op_t'({s_tdata[41:0], s_tuser})));
      end
      if (!(s_tvalid && !s_tready)) begin
        if (tx_gap > 0) begin
          tx_gap--;
          s_tvalid <= 1'b0;
        end else if (pending_ops.size() > 0) begin
          op = pending_ops.pop_front();
          s_tdata <= {6'b0, op.new_priority, op.value, op.sem_index, op.task_index};
          s_tuser <= op.mode;
          s_tvalid <= 1'b1;
          if (!calm && $urandom_range(0, 5) == 0) tx_gap = $urandom_range(1, 13);
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got.task_out = m_tdata[3:0];
        got.task_valid = m_tuser;
        got.fresh_start = m_tdata[4];
        got.switch_request = m_tdata[5];
        got.error = m_tdata[7:6];
        if (expected_results.size() == 0) report("unexpected result", 16'(m_tdata), '0);
        else begin
          want = expected_results.pop_front();
          if (got.task_out !== want.task_out) report("task_out", got.task_out, want.task_out);
          if (got.task_valid !== want.task_valid)
            report("task_valid", got.task_valid, want.task_valid);
          if (got.fresh_start !== want.fresh_start)
            report("fresh_start", got.fresh_start, want.fresh_start);
          if (got.switch_request !== want.switch_request)
            report("switch_request", got.switch_request, want.switch_request);
          if (got.error !== want.error) report("error", got.error, want.error);
        end
      end
      if (hold_cycles > 0) m_tready <= 1'b0;
      else if (rx_gap > 0) begin
        rx_gap--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        if (!calm && $urandom_range(0, 5) == 0) rx_gap = $urandom_range(1, 13);
      end
    end
  end

  // receiver hold-off countdown
  always @(posedge clk) begin
    if (hold_cycles > 0) hold_cycles--;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic op_t make_op(int m, int ti, int si, int unsigned v, int np);
    op_t o;
    o.mode = 4'(m);
    o.task_index = 4'(ti);
    o.sem_index = 3'(si);
    o.value = 32'(v);
    o.new_priority = 3'(np);
    return o;
  endfunction

  // mostly well-formed kernel traffic; well-formed waits and posts use semaphores 0..4
  function automatic op_t random_op();
    int pick;
    logic [31:0] v;
    logic [63:0] raw;
    pick = $urandom_range(0, 99);
    v = ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 4);
    raw = {$urandom(), $urandom()};
    if (pick < 3) return op_t'(raw[45:0]);
    if (pick < 18) return make_op(M_TICK, 0, 0, 0, 0);
    if (pick < 38) return make_op(M_SCHED, 0, 0, 0, 0);
    if (pick < 46) return make_op(M_SLEEP, 0, 0, v, 0);
    if (pick < 58) return make_op(M_WAIT, 0, $urandom_range(0, 4), 0, 0);
    if (pick < 70) return make_op(M_POST, 0, $urandom_range(0, 4), 0, 0);
    if (pick < 80) return make_op(M_RESTART, $urandom_range(0, 11), 0, 0, 0);
    if (pick < 85) return make_op(M_STOP, $urandom_range(0, 11), 0, 0, 0);
    if (pick < 92) return make_op(M_SETPRI, $urandom_range(0, 11), 0, 0, $urandom_range(0, 7));
    if (pick < 97) return make_op(M_INITSEM, 0, $urandom_range(0, 4), v, 0);
    return make_op($urandom_range(0, 8), $urandom_range(12, 15), $urandom_range(5, 7),
                   $urandom(), $urandom_range(0, 7));
  endfunction

  task automatic drain();
    while (pending_ops.size() > 0 || expected_results.size() > 0 || s_tvalid)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_cfg(logic idx, logic val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    if (idx == CFG_PREEMPT) k_preempt = val;
    else k_prio_mode = val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    for (int t = 0; t < NT; t++) begin
      k_state[t] = ST_INVALID;
      k_prio[t] = 3'd7;
      k_ticks[t] = '0;
      k_wsem[t] = '0;
      k_waiting[t] = 1'b0;
    end
    for (int s = 0; s < NS; s++) begin
      k_count[s] = '0;
      k_qlen[s] = 0;
    end
    k_cur = 0;
    k_last = NT - 1;
    k_preempt = 1'b0;
    k_prio_mode = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    write_cfg(CFG_PREEMPT, 1'b1);

    // directed: empty schedule, range errors, queue full, saturation, unknown mode
    pending_ops.push_back(make_op(M_SCHED, 0, 0, 0, 0));
    pending_ops.push_back(make_op(M_STOP, 3, 0, 0, 0));
    pending_ops.push_back(make_op(M_RESTART, 15, 0, 0, 0));
    pending_ops.push_back(make_op(M_SETPRI, 12, 0, 0, 7));
    pending_ops.push_back(make_op(M_WAIT, 0, 7, 0, 0));
    pending_ops.push_back(make_op(M_INITSEM, 0, 5, 32'hFFFF_FFFF, 0));
    for (int t = 0; t < 6; t++) pending_ops.push_back(make_op(M_RESTART, t, 0, 0, 0));
    for (int t = 0; t < 6; t++) begin
      pending_ops.push_back(make_op(M_SCHED, 0, 0, 0, 0));
      pending_ops.push_back(make_op(M_WAIT, 0, 4, 0, 0));
    end
    pending_ops.push_back(make_op(M_POST, 0, 4, 0, 0));
    pending_ops.push_back(make_op(M_STOP, 2, 0, 0, 0));
    pending_ops.push_back(make_op(M_INITSEM, 0, 1, 32'h0001_FFFF, 0));
    pending_ops.push_back(make_op(M_POST, 0, 1, 0, 0));
    pending_ops.push_back(make_op(M_SCHED, 0, 0, 0, 0));
    pending_ops.push_back(make_op(M_SLEEP, 0, 0, 32'hFFFF_FFFF, 0));
    pending_ops.push_back(make_op(M_TICK, 0, 0, 0, 0));
    pending_ops.push_back(make_op(15, 15, 7, 32'hFFFF_FFFF, 7));
    drain();

    write_cfg(CFG_PRIO, 1'b1);
    write_cfg(CFG_PREEMPT, 1'b0);
    for (int i = 0; i < 200; i++) pending_ops.push_back(random_op());
    // long receiver hold-off while the sender keeps offering
    hold_cycles = 300;
    drain();

    write_cfg(CFG_PRIO, 1'b0);
    write_cfg(CFG_PREEMPT, 1'b1);
    for (int i = 0; i < 250; i++) pending_ops.push_back(random_op());
    drain();

    write_cfg(CFG_PRIO, 1'b1);
    calm = 1'b1;
    for (int i = 0; i < 250; i++) pending_ops.push_back(random_op());
    drain();

    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule

// File: files.f
+incdir+sv
sv/tse_pkg.sv
sv/task_scheduler_semaphore_engine_top.sv
sim/tb_task_scheduler_semaphore_engine_top.sv
